FILE: rtl/bline_pkg.sv
// ----------------------------------------------------------------------------
// Line rasteriser package
// Shared widths, word types and control codes for the line rasteriser.
// ----------------------------------------------------------------------------
package bline_pkg;

  // Grid coordinate width (the grid is 2^CoordBits on each side).
  localparam int unsigned CoordBits = 6;
  // Decision variable width: it holds sums of a few doubled deltas with sign.
  localparam int unsigned DecBits = CoordBits + 4;
  // Default number of line setups held between the front and the back part.
  localparam int unsigned QueueDepthDef = 2;

  typedef logic [CoordBits-1:0]      coord_t;
  typedef logic signed [DecBits-1:0] dec_t;

  // Drawing direction of one line.
  typedef enum logic [1:0] {
    SLOPE_SHALLOW_UP   = 2'd0,
    SLOPE_SHALLOW_DOWN = 2'd1,
    SLOPE_STEEP_RIGHT  = 2'd2,
    SLOPE_STEEP_LEFT   = 2'd3
  } slope_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_DRAW = 1'b1
  } back_state_e;

  // Input word: one line command.
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } cmd_t;

  // Output word: one plotted pixel.
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } pixel_t;

  // Classified line, ready for stepping.
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t stop_coord;
    dec_t   decision;
    dec_t   inc_move;
    dec_t   inc_stay;
    slope_e slope_mode;
  } setup_t;

endpackage

FILE: rtl/bline_front.sv
// ----------------------------------------------------------------------------
// Line rasteriser front part
// Accepts line commands, orders the endpoints and works out the initial
// decision value and increments, then pushes the setup into the queue.
// ----------------------------------------------------------------------------
module bline_front import bline_pkg::*; (
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  cmd_t   in_data_i,
  input  logic   q_full_i,
  output logic   push_o,
  output setup_t setup_o
);

  dec_t   x0, y0, x1, y1;
  dec_t   dx, dy, adx, ady;
  dec_t   ddx, ddy;
  logic   shallow, swap;
  coord_t sx0, sy0, sx1, sy1;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    x0 = dec_t'(in_data_i.start_x);
    y0 = dec_t'(in_data_i.start_y);
    x1 = dec_t'(in_data_i.end_x);
    y1 = dec_t'(in_data_i.end_y);
    dx = x1 - x0;
    dy = y1 - y0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    // A vertical line or a single point goes down the steep path.
    shallow = (dx != '0) && (ady <= adx);
    swap    = shallow ? (dx < 0) : (dy < 0);

    sx0 = swap ? in_data_i.end_x   : in_data_i.start_x;
    sy0 = swap ? in_data_i.end_y   : in_data_i.start_y;
    sx1 = swap ? in_data_i.start_x : in_data_i.end_x;
    sy1 = swap ? in_data_i.start_y : in_data_i.end_y;
    ddx = swap ? -dx : dx;
    ddy = swap ? -dy : dy;

    setup_o.start_x = sx0;
    setup_o.start_y = sy0;
    if (shallow) begin
      setup_o.stop_coord = sx1;
      setup_o.inc_stay   = -(ddy <<< 1);
      if (ddy >= 0) begin
        setup_o.slope_mode = SLOPE_SHALLOW_UP;
        setup_o.decision   = ddx - (ddy <<< 1);
        setup_o.inc_move   = (ddx <<< 1) - (ddy <<< 1);
      end else begin
        setup_o.slope_mode = SLOPE_SHALLOW_DOWN;
        setup_o.decision   = -ddx - (ddy <<< 1);
        setup_o.inc_move   = -(ddx <<< 1) - (ddy <<< 1);
      end
    end else begin
      setup_o.stop_coord = sy1;
      setup_o.inc_stay   = ddx <<< 1;
      if (ddx >= 0) begin
        setup_o.slope_mode = SLOPE_STEEP_RIGHT;
        setup_o.decision   = (ddx <<< 1) - ddy;
        setup_o.inc_move   = (ddx <<< 1) - (ddy <<< 1);
      end else begin
        setup_o.slope_mode = SLOPE_STEEP_LEFT;
        setup_o.decision   = (ddx <<< 1) + ddy;
        setup_o.inc_move   = (ddx <<< 1) + (ddy <<< 1);
      end
    end
  end

endmodule

FILE: rtl/bline_queue.sv
// ----------------------------------------------------------------------------
// Line rasteriser setup queue
// A small first-in first-out store of classified lines between the parts.
// ----------------------------------------------------------------------------
module bline_queue import bline_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  setup_t data_i,
  input  logic   pop_i,
  output setup_t data_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int unsigned AddrBits  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountBits = $clog2(DEPTH + 1);
  localparam logic [AddrBits-1:0]  LastAddr = AddrBits'(DEPTH - 1);
  localparam logic [CountBits-1:0] FullCount = CountBits'(DEPTH);

  setup_t               mem_q [DEPTH];
  logic [AddrBits-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrBits-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CountBits-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCount);
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/bline_back.sv
// ----------------------------------------------------------------------------
// Line rasteriser back part
// Takes one setup from the queue and steps along the major axis, one pixel
// a cycle while the output side takes words, into a registered output word.
// ----------------------------------------------------------------------------
module bline_back import bline_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_empty_i,
  input  setup_t setup_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output pixel_t out_data_o
);

  back_state_e state_q, state_d;
  coord_t      cur_x_q, cur_y_q, stop_q;
  dec_t        dec_q, move_q, stay_q;
  slope_e      mode_q;
  logic        out_valid_q, out_valid_d;
  pixel_t      out_q;

  logic   advance, last, step;
  coord_t major, nx, ny;

  assign major = (mode_q == SLOPE_SHALLOW_UP || mode_q == SLOPE_SHALLOW_DOWN)
                 ? cur_x_q : cur_y_q;
  assign last  = (major == stop_q);

  always_comb begin
    case (mode_q)
      SLOPE_SHALLOW_UP: begin
        step = dec_q < 0;
        nx   = cur_x_q + 1'b1;
        ny   = step ? cur_y_q + 1'b1 : cur_y_q;
      end
      SLOPE_SHALLOW_DOWN: begin
        step = dec_q >= 0;
        nx   = cur_x_q + 1'b1;
        ny   = step ? cur_y_q - 1'b1 : cur_y_q;
      end
      SLOPE_STEEP_RIGHT: begin
        step = dec_q > 0;
        ny   = cur_y_q + 1'b1;
        nx   = step ? cur_x_q + 1'b1 : cur_x_q;
      end
      default: begin
        step = dec_q <= 0;
        ny   = cur_y_q + 1'b1;
        nx   = step ? cur_x_q - 1'b1 : cur_x_q;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = BK_DRAW;
        end
      end
      BK_DRAW: begin
        if (advance && last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    pop_o       = (state_q == BK_IDLE) && !q_empty_i;
    advance     = (state_q == BK_DRAW) && (!out_valid_q || out_ready_i);
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_x_q <= setup_i.start_x;
      cur_y_q <= setup_i.start_y;
      stop_q  <= setup_i.stop_coord;
      dec_q   <= setup_i.decision;
      move_q  <= setup_i.inc_move;
      stay_q  <= setup_i.inc_stay;
      mode_q  <= setup_i.slope_mode;
    end else if (advance) begin
      out_q.pixel_x    <= cur_x_q;
      out_q.pixel_y    <= cur_y_q;
      out_q.last_pixel <= last;
      cur_x_q          <= nx;
      cur_y_q          <= ny;
      dec_q            <= dec_q + (step ? move_q : stay_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// Bresenham line rasteriser
// Draws lines on a square grid with the midpoint decision method, in all
// octants, and sends out one word per pixel with the last one marked.
// ----------------------------------------------------------------------------
// A line command is taken in as one word with two endpoints and comes out as
// one word per pixel, in drawing order, with last_pixel set on the final one.
// The front part orders the endpoints and computes the start decision value
// in the cycle the command is accepted, and places the result in a queue of
// QUEUE_DEPTH lines; so new commands are taken while an earlier line is still
// being drawn, until the queue is full. The back part's stepping loop sets
// the rate: it loads a line from the queue and then plots one pixel each
// cycle while the output side takes words; a line has n pixels (n = 1 +
// the longer of |dx| and |dy|, at most 64). On its way to the output, a
// line's setup is written into the queue, loaded into the back part's
// registers and then stepped into the registered output word. Shallow
// lines (|dy| <= |dx| and dx not zero) are drawn towards increasing x; all
// others, vertical lines and single points included, towards increasing y.
module bresenham_line_rasterizer import bline_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  cmd_t   in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output pixel_t out_data_o
);

  // Handshake between the front part, the queue and the back part.
  logic   q_push, q_pop, q_full, q_empty;
  setup_t q_wr_data, q_rd_data;

  // Front part: classifies each command and works out its start values.
  bline_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .setup_o    (q_wr_data)
  );

  // Queue of classified lines, so that each part may stall on its own.
  bline_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_data),
    .pop_i   (q_pop),
    .data_o  (q_rd_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back part: steps along each line and holds the outgoing pixel word.
  bline_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .setup_i     (q_rd_data),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The queue must never be written when full or read when empty.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("line queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("line queue read while empty");

  // A pixel word on offer stays on offer, unchanged, until it is taken.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("pixel word changed or dropped before it was taken");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasteriser testbench
// Sends line commands into the rasteriser, works out every pixel each line
// should produce with its own midpoint stepper, and checks the pixel words
// that come back in order, under random idling and long output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import bline_pkg::*;

  // Generous cycle budget: about 340 lines of at most 64 pixels each, every
  // pixel possibly waiting out a receiver stall, plus the long hold-off.
  localparam int unsigned CycleLimit = 400_000;
  // Length of the deliberate receiver hold-off, in cycles.
  localparam int unsigned HoldCycles = 400;
  // Idle chance, in percent, on each side when idling is enabled.
  localparam int unsigned IdlePct = 14;
  // Only the first few mismatches are printed; all of them are counted.
  localparam int unsigned MaxReported = 40;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_ready_o;
  cmd_t   in_data_i   = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  pixel_t out_data_o;

  // Line commands waiting to be offered, and pixel words still owed by the
  // block, oldest first.
  cmd_t        lines_to_send[$];
  pixel_t      pixels_due[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // When set, neither side idles at random.
  bit          steady_flow = 1'b0;
  // A one-cycle request that starts the receiver hold-off.
  bit          hold_req    = 1'b0;
  int unsigned hold_left   = 0;

  bresenham_line_rasterizer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Expected pixels. The endpoints are put in drawing order, the line is
  // classed as shallow (|dy| <= |dx| with dx not zero) or steep, and the
  // midpoint decision value is then stepped one pixel at a time. Ties on a
  // zero decision go the way each of the four directions defines: shallow
  // rising and steep rising hold the minor coordinate, the two falling
  // directions step it.
  // --------------------------------------------------------------------------
  task automatic rasterise_line(input cmd_t c);
    int     x0, y0, x1, y1, dx, dy, adx, ady, swap_tmp;
    int     decision, inc_move, inc_stay, n_pixels, i;
    bit     shallow, stepped;
    slope_e dir;
    coord_t px, py;
    pixel_t w;
    x0  = c.start_x;
    y0  = c.start_y;
    x1  = c.end_x;
    y1  = c.end_y;
    dx  = x1 - x0;
    dy  = y1 - y0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    // A vertical line or a single point always goes down the steep path.
    shallow = (dx != 0) && (ady <= adx);
    if ((shallow && x0 > x1) || (!shallow && y0 > y1)) begin
      swap_tmp = x0; x0 = x1; x1 = swap_tmp;
      swap_tmp = y0; y0 = y1; y1 = swap_tmp;
    end
    dx = x1 - x0;
    dy = y1 - y0;
    if (shallow) begin
      if (dy >= 0) begin
        dir      = SLOPE_SHALLOW_UP;
        decision = dx - 2 * dy;
        inc_move = 2 * dx - 2 * dy;
      end else begin
        dir      = SLOPE_SHALLOW_DOWN;
        decision = -dx - 2 * dy;
        inc_move = -2 * dx - 2 * dy;
      end
      inc_stay = -2 * dy;
      n_pixels = dx + 1;
    end else begin
      if (dx >= 0) begin
        dir      = SLOPE_STEEP_RIGHT;
        decision = 2 * dx - dy;
        inc_move = 2 * dx - 2 * dy;
      end else begin
        dir      = SLOPE_STEEP_LEFT;
        decision = 2 * dx + dy;
        inc_move = 2 * dx + 2 * dy;
      end
      inc_stay = 2 * dx;
      n_pixels = dy + 1;
    end
    px = coord_t'(x0);
    py = coord_t'(y0);
    for (i = 0; i < n_pixels; i++) begin
      w.pixel_x    = px;
      w.pixel_y    = py;
      w.last_pixel = (i == n_pixels - 1);
      pixels_due.push_back(w);
      case (dir)
        SLOPE_SHALLOW_UP: begin
          stepped = (decision < 0);
          px++;
          if (stepped) py++;
        end
        SLOPE_SHALLOW_DOWN: begin
          stepped = (decision >= 0);
          px++;
          if (stepped) py--;
        end
        SLOPE_STEEP_RIGHT: begin
          stepped = (decision > 0);
          py++;
          if (stepped) px++;
        end
        default: begin
          stepped = (decision <= 0);
          py++;
          if (stepped) px--;
        end
      endcase
      decision += stepped ? inc_move : inc_stay;
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MaxReported) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Each pixel word that leaves the block must match the oldest one owed.
  task automatic check_pixel(input pixel_t got);
    pixel_t want;
    if (pixels_due.size() == 0) begin
      report_mismatch($sformatf("pixel word (%0d,%0d) last=%0b with none owed",
                                got.pixel_x, got.pixel_y, got.last_pixel));
      return;
    end
    want = pixels_due.pop_front();
    if (got.pixel_x !== want.pixel_x) begin
      report_mismatch($sformatf("pixel_x %0d, wanted %0d", got.pixel_x, want.pixel_x));
    end
    if (got.pixel_y !== want.pixel_y) begin
      report_mismatch($sformatf("pixel_y %0d, wanted %0d", got.pixel_y, want.pixel_y));
    end
    if (got.last_pixel !== want.last_pixel) begin
      report_mismatch($sformatf("last_pixel %0b, wanted %0b at (%0d,%0d)",
                                got.last_pixel, want.last_pixel,
                                want.pixel_x, want.pixel_y));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender. A command word is predicted at the edge where it is accepted.
  // The valid line only changes once the current word has gone (or none was
  // offered), so a word on offer is held steady until the block takes it.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        rasterise_line(in_data_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (lines_to_send.size() != 0 &&
            (steady_flow || $urandom_range(99) >= IdlePct)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= lines_to_send.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver. Ready is decided afresh every cycle, and is held low for the
  // whole of the hold-off so that the block backs up onto its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_pixel(out_data_o);
      end
      out_ready_i <= (hold_left == 0) &&
                     (steady_flow || $urandom_range(99) >= IdlePct);
    end
  end

  // The hold-off has its own cycle count, started by a one-cycle request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. Queue updates happen at the falling edge, away from the
  // sender's rising-edge work.
  // --------------------------------------------------------------------------
  task automatic queue_line(input int x0, input int y0, input int x1, input int y1);
    cmd_t c;
    c.start_x = coord_t'(x0);
    c.start_y = coord_t'(y0);
    c.end_x   = coord_t'(x1);
    c.end_y   = coord_t'(y1);
    lines_to_send.push_back(c);
  endtask

  // Short lines and lines anywhere on the grid in equal shares, plus single
  // points and lines along an axis.
  task automatic queue_random_line();
    int x0, y0, x1, y1, dxr, dyr;
    x0 = $urandom_range(63);
    y0 = $urandom_range(63);
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        x1 = $urandom_range(63);
        y1 = $urandom_range(63);
      end
      4, 5, 6, 7: begin
        dxr = int'($urandom_range(14)) - 7;
        dyr = int'($urandom_range(14)) - 7;
        x1  = x0 + dxr;
        y1  = y0 + dyr;
        if (x1 < 0 || x1 > 63) x1 = x0 - dxr;
        if (y1 < 0 || y1 > 63) y1 = y0 - dyr;
      end
      8: begin
        x1 = x0;
        y1 = y0;
      end
      default: begin
        if ($urandom_range(1) != 0) begin
          x1 = x0;
          y1 = $urandom_range(63);
        end else begin
          x1 = $urandom_range(63);
          y1 = y0;
        end
      end
    endcase
    queue_line(x0, y0, x1, y1);
  endtask

  // The sender stops here until the block owes nothing more.
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (lines_to_send.size() != 0 || in_valid_i || pixels_due.size() != 0);
  endtask

  initial begin
    int k;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed lines: single points at both corners, vertical and horizontal
    // lines both ways, full diagonals in all four directions, a midpoint tie
    // in each drawing direction, swapped endpoints, and alternating bit
    // patterns on every coordinate.
    queue_line( 0,  0,  0,  0);
    queue_line(63, 63, 63, 63);
    queue_line(10,  5, 10, 60);
    queue_line(63, 63, 63,  0);
    queue_line( 0,  0, 63,  0);
    queue_line(63, 63,  0, 63);
    queue_line( 0,  0, 63, 63);
    queue_line(63, 63,  0,  0);
    queue_line( 0, 63, 63,  0);
    queue_line(63,  0,  0, 63);
    queue_line( 0,  0,  2,  1);
    queue_line( 0,  1,  2,  0);
    queue_line( 0,  0,  1,  2);
    queue_line( 1,  0,  0,  2);
    queue_line(40, 30,  3, 12);
    queue_line( 5, 50, 60, 20);
    queue_line( 7,  2, 30, 61);
    queue_line(50, 60, 20,  1);
    queue_line(42, 21, 21, 42);
    queue_line(21, 42, 42, 21);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering words, so the
    // block's line queue fills and it stops taking commands.
    steady_flow = 1'b1;
    hold_req    = 1'b1;
    @(negedge clk_i);
    hold_req    = 1'b0;
    for (k = 0; k < 16; k++) queue_random_line();
    wait_drained();

    // Random lines: idling on both sides, then a long stretch with none,
    // then idling again.
    steady_flow = 1'b0;
    for (k = 0; k < 150; k++) queue_random_line();
    wait_drained();
    steady_flow = 1'b1;
    for (k = 0; k < 80; k++) queue_random_line();
    wait_drained();
    steady_flow = 1'b0;
    for (k = 0; k < 70; k++) queue_random_line();
    wait_drained();

    // A short tail catches any stray pixel words after the last line.
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pixels_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
